@@ rtl/lwip_pkg.sv @@
// lwip_pkg: shared types and constants for the least-worn item pool
// used by lwip_cell, lwip_chain and least_worn_item_pool_unit
package lwip_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int ID_BITS     = 6;
  localparam int COUNT_BITS  = 8;
  localparam int STAMP_BITS  = 32;
  localparam int SIZE_BITS   = $clog2(MAX_ITEMS + 1);
  localparam int LIMIT_BITS  = 8;

  // request codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_BORROW = 2'd1;
  localparam logic [1:0] FUNC_RETURN = 2'd2;
  localparam logic [1:0] FUNC_QUERY  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BORROWED = 2'd0;
  localparam logic [1:0] KIND_RETIRED  = 2'd1;
  localparam logic [1:0] KIND_SIZE     = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_EMPTY        = 2'd1;
  localparam logic [1:0] ERR_NOT_BORROWED = 2'd2;
  localparam logic [1:0] ERR_PRESENT      = 2'd3;

  // register map
  localparam logic [1:0] REG_RETIRE_LIMIT = 2'd0;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd3;

  typedef enum logic [1:0] {
    LOC_ABSENT   = 2'd0,
    LOC_POOLED   = 2'd1,
    LOC_BORROWED = 2'd2
  } loc_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // one queue slot: ordered by count, then by stamp
  typedef struct packed {
    logic                  valid;
    logic [ID_BITS-1:0]    id;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } chain_ctl_t;

endpackage

@@ rtl/lwip_cell.sv @@
// lwip_cell: one slot of the sorted queue, compares against the new entry
// and takes from its neighbors on insert or pop; uses lwip_pkg
module lwip_cell
  import lwip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  entry_t     new_ent,
  input  entry_t     prev_ent,
  input  entry_t     next_ent,
  input  logic       prev_gt,
  output entry_t     ent,
  output logic       gt
);

  entry_t ent_r;
  entry_t ent_nxt;

  // slot lies after the insert point when empty or holding a larger key
  assign gt = !ent_r.valid ||
              ({ent_r.count, ent_r.stamp} > {new_ent.count, new_ent.stamp});

  // take new entry at the insert point, shift right behind it, shift left on pop
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.pop) begin
      ent_nxt = next_ent;
    end else if (ctl.ins && gt) begin
      if (prev_gt) begin
        ent_nxt = prev_ent;
      end else begin
        ent_nxt = new_ent;
        ent_nxt.valid = 1'b1;
      end
    end
  end

  // slot register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.id    <= ent_nxt.id;
    ent_r.count <= ent_nxt.count;
    ent_r.stamp <= ent_nxt.stamp;
  end

  assign ent = ent_r;

endmodule

@@ rtl/lwip_chain.sv @@
// lwip_chain: row of lwip_cell slots kept sorted, head holds the least-worn item
// depends on lwip_pkg and lwip_cell
module lwip_chain
  import lwip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  entry_t     new_ent,
  output entry_t     head
);

  entry_t ent [MAX_ITEMS];
  logic   gt  [MAX_ITEMS];
  entry_t empty_ent;

  assign empty_ent = '0;

  // slots linked to both neighbors
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_g;
    if (i == 0) begin : g_first
      assign prev_e = empty_ent;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_g = gt[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_e = empty_ent;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end
    lwip_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_ent  (new_ent),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .prev_gt  (prev_g),
      .ent      (ent[i]),
      .gt       (gt[i])
    );
  end

  assign head = ent[0];

endmodule

@@ rtl/least_worn_item_pool_unit.sv @@
// least_worn_item_pool_unit: top level of the least-worn item pool
// depends on lwip_pkg and lwip_chain (which uses lwip_cell)
//
// Each request is accepted and then executed in S_EXEC, after the registered
// reads of the item location table and the borrowed-record memory.
// Execution waits while the result register is full and stalled. Pooled
// items live in a sorted chain of 64 cells, head first, so insert and borrow
// both finish in the execute cycle. No clearing pass is needed after reset.
module least_worn_item_pool_unit
  import lwip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [ID_BITS-1:0]    in_item_id,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_result_kind,
  output logic [ID_BITS-1:0]    out_result_id,
  output logic [SIZE_BITS-1:0]  out_pool_count,
  output logic [1:0]            out_error_code,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int REC_BITS = COUNT_BITS + STAMP_BITS;

  state_t state_r, state_nxt;
  logic [1:0]             cmd_func_r;
  logic [ID_BITS-1:0]     cmd_id_r;
  logic [LIMIT_BITS-1:0]  limit_r;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic [STAMP_BITS-1:0]  stamp_r, stamp_nxt;
  loc_t                   loc_r [MAX_ITEMS];
  logic                   loc_we;
  loc_t                   loc_wval;
  logic [ID_BITS-1:0]     loc_waddr;
  logic [REC_BITS-1:0]    rec_mem [MAX_ITEMS];
  logic [REC_BITS-1:0]    rec_rd_r;
  logic                   rec_we;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic [ID_BITS-1:0]     out_id_r, out_id_nxt;
  logic [SIZE_BITS-1:0]   out_cnt_r, out_cnt_nxt;
  logic [1:0]             out_err_r, out_err_nxt;
  logic                   in_acc;
  logic                   out_free;
  logic                   exec_go;
  chain_ctl_t             ctl;
  entry_t                 new_ent;
  entry_t                 head;
  loc_t                   cmd_loc_r;
  logic [COUNT_BITS-1:0]  ret_count;
  logic                   stamps_out;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign exec_go    = (state_r == S_EXEC) && out_free;
  assign stamps_out = (stamp_r == {STAMP_BITS{1'b1}});

  // returned count, saturating
  assign ret_count = (rec_rd_r[REC_BITS-1 -: COUNT_BITS] == {COUNT_BITS{1'b1}}) ?
                     rec_rd_r[REC_BITS-1 -: COUNT_BITS] :
                     rec_rd_r[REC_BITS-1 -: COUNT_BITS] + 1'b1;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_RETIRE_LIMIT) ? {{(32-LIMIT_BITS){1'b0}}, limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      limit_r <= pwdata[LIMIT_BITS-1:0];
    end
  end

  // next state, request execution and result
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    stamp_nxt     = stamp_r;
    ctl           = '0;
    new_ent       = '0;
    loc_we        = 1'b0;
    loc_wval      = LOC_ABSENT;
    loc_waddr     = cmd_id_r;
    rec_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_cnt_nxt   = out_cnt_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt    = S_IDLE;
          out_kind_nxt = KIND_ERROR;
          out_id_nxt   = '0;
          out_cnt_nxt  = '0;
          out_err_nxt  = ERR_NONE;
          unique case (cmd_func_r)
            FUNC_ADD: begin
              if (cmd_loc_r != LOC_ABSENT || stamps_out) begin
                out_valid_nxt = 1'b1;
                out_err_nxt   = ERR_PRESENT;
              end else begin
                ctl.ins       = 1'b1;
                new_ent.id    = cmd_id_r;
                new_ent.count = '0;
                new_ent.stamp = stamp_r;
                loc_we        = 1'b1;
                loc_wval      = LOC_POOLED;
                stamp_nxt     = stamp_r + 1'b1;
                size_nxt      = size_r + 1'b1;
              end
            end
            FUNC_BORROW: begin
              out_valid_nxt = 1'b1;
              if (size_r == '0) begin
                out_err_nxt = ERR_EMPTY;
              end else begin
                ctl.pop      = 1'b1;
                loc_we       = 1'b1;
                loc_wval     = LOC_BORROWED;
                loc_waddr    = head.id;
                rec_we       = 1'b1;
                size_nxt     = size_r - 1'b1;
                out_kind_nxt = KIND_BORROWED;
                out_id_nxt   = head.id;
              end
            end
            FUNC_RETURN: begin
              if (cmd_loc_r != LOC_BORROWED) begin
                out_valid_nxt = 1'b1;
                out_err_nxt   = ERR_NOT_BORROWED;
              end else if (ret_count >= limit_r) begin
                loc_we        = 1'b1;
                loc_wval      = LOC_ABSENT;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_RETIRED;
                out_id_nxt    = cmd_id_r;
              end else begin
                ctl.ins       = 1'b1;
                new_ent.id    = cmd_id_r;
                new_ent.count = ret_count;
                new_ent.stamp = rec_rd_r[STAMP_BITS-1:0];
                loc_we        = 1'b1;
                loc_wval      = LOC_POOLED;
                size_nxt      = size_r + 1'b1;
              end
            end
            FUNC_QUERY: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_SIZE;
              out_cnt_nxt   = size_r;
            end
            default: begin
              out_valid_nxt = out_valid_r && out_stall;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item location table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
        loc_r[i] <= LOC_ABSENT;
      end
    end else if (loc_we) begin
      loc_r[loc_waddr] <= loc_wval;
    end
  end

  // request and result payload registers, location read with the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_func_r <= in_func;
      cmd_id_r   <= in_item_id;
      cmd_loc_r  <= loc_r[in_item_id];
    end
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_err_r  <= out_err_nxt;
  end

  // borrowed-record memory: count and stamp of each item out on loan
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[head.id] <= {head.count, head.stamp};
    end
    if (in_acc) begin
      rec_rd_r <= rec_mem[in_item_id];
    end
  end

  // sorted queue of pooled items
  lwip_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .new_ent (new_ent),
    .head    (head)
  );

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_result_id   = out_id_r;
  assign out_pool_count  = out_cnt_r;
  assign out_error_code  = out_err_r;

`ifndef SYNTHESIS
  // head slot is occupied exactly when the pool is not empty
  a_head_vs_size: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r != '0) == head.valid)
    else $error("queue head disagrees with pool size");

  // a borrowed item must be marked pooled
  a_borrow_pooled: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop) |-> (loc_r[head.id] == LOC_POOLED))
    else $error("borrowed item was not pooled");

  // a new result only appears after an execute cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result produced outside execution");

  // the pool never grows beyond its capacity
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |-> (size_r < SIZE_BITS'(MAX_ITEMS)))
    else $error("insert into a full queue");
`endif

endmodule

@@ test/lwip_pool_model.sv @@
// lwip_pool_model: expected-result tracker for the least-worn item pool testbench
// predicts each request's outcome and checks results in order; depends on lwip_pkg
`timescale 1ns / 100ps

package lwip_pool_model_pkg;
  import lwip_pkg::*;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ID_BITS-1:0]   id;
    logic [SIZE_BITS-1:0] cnt;
    logic [1:0]           err;
  } pool_result_t;

  localparam logic [STAMP_BITS-1:0] STAMP_LAST = {STAMP_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_TOP  = {COUNT_BITS{1'b1}};

  class item_pool_model;
    loc_t                  place [MAX_ITEMS];
    logic [COUNT_BITS-1:0] uses [MAX_ITEMS];
    logic [STAMP_BITS-1:0] stamp [MAX_ITEMS];
    int                    pooled;
    logic [STAMP_BITS-1:0] stamp_next;
    logic [LIMIT_BITS-1:0] limit;
    pool_result_t          due_results [$];
    int                    mismatches;

    function new();
      for (int i = 0; i < MAX_ITEMS; i++) begin
        place[i] = LOC_ABSENT;
        uses[i]  = '0;
        stamp[i] = '0;
      end
      pooled     = 0;
      stamp_next = '0;
      limit      = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_limit(logic [LIMIT_BITS-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // random item currently in the wanted place, or -1 if there is none
    function int find_item(loc_t want);
      int start;
      start = $urandom_range(0, MAX_ITEMS - 1);
      for (int k = 0; k < MAX_ITEMS; k++) begin
        if (place[(start + k) % MAX_ITEMS] == want) return (start + k) % MAX_ITEMS;
      end
      return -1;
    endfunction

    function void await_result(logic [1:0] kind, logic [ID_BITS-1:0] id,
                               logic [SIZE_BITS-1:0] cnt, logic [1:0] err);
      pool_result_t r;
      r.kind = kind;
      r.id   = id;
      r.cnt  = cnt;
      r.err  = err;
      due_results.push_back(r);
    endfunction

    // update the pool for one accepted request and queue its result, if any
    function void take_request(logic [1:0] func, logic [ID_BITS-1:0] id);
      int                    best;
      logic [COUNT_BITS-1:0] c;
      case (func)
        FUNC_ADD: begin
          if (place[id] != LOC_ABSENT || stamp_next == STAMP_LAST) begin
            await_result(KIND_ERROR, '0, '0, ERR_PRESENT);
          end else begin
            place[id]  = LOC_POOLED;
            uses[id]   = '0;
            stamp[id]  = stamp_next;
            stamp_next = stamp_next + 1'b1;
            pooled++;
          end
        end
        FUNC_BORROW: begin
          // lowest count wins, oldest stamp on ties
          best = -1;
          for (int i = 0; i < MAX_ITEMS; i++) begin
            if (place[i] == LOC_POOLED &&
                (best < 0 || uses[i] < uses[best] ||
                 (uses[i] == uses[best] && stamp[i] < stamp[best]))) best = i;
          end
          if (best < 0) begin
            await_result(KIND_ERROR, '0, '0, ERR_EMPTY);
          end else begin
            place[best] = LOC_BORROWED;
            pooled--;
            await_result(KIND_BORROWED, ID_BITS'(best), '0, ERR_NONE);
          end
        end
        FUNC_RETURN: begin
          if (place[id] != LOC_BORROWED) begin
            await_result(KIND_ERROR, '0, '0, ERR_NOT_BORROWED);
          end else begin
            // count saturates before the compare
            c = uses[id];
            if (c != COUNT_TOP) c = c + 1'b1;
            if (c >= limit) begin
              place[id] = LOC_ABSENT;
              uses[id]  = '0;
              await_result(KIND_RETIRED, id, '0, ERR_NONE);
            end else begin
              uses[id]  = c;
              place[id] = LOC_POOLED;
              pooled++;
            end
          end
        end
        default: begin
          await_result(KIND_SIZE, '0, SIZE_BITS'(pooled), ERR_NONE);
        end
      endcase
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(logic [1:0] kind, logic [ID_BITS-1:0] id,
                               logic [SIZE_BITS-1:0] cnt, logic [1:0] err);
      pool_result_t r;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d id %0d count %0d error %0d", kind, id, cnt, err);
        mismatches++;
        return;
      end
      r = due_results.pop_front();
      if (kind !== r.kind) begin
        $error("result_kind: expected %0d, got %0d", r.kind, kind);
        mismatches++;
      end
      if (id !== r.id) begin
        $error("result_id: expected %0d, got %0d", r.id, id);
        mismatches++;
      end
      if (cnt !== r.cnt) begin
        $error("pool_count: expected %0d, got %0d", r.cnt, cnt);
        mismatches++;
      end
      if (err !== r.err) begin
        $error("error_code: expected %0d, got %0d", r.err, err);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ test/least_worn_item_pool_unit_tb.sv @@
// least_worn_item_pool_unit_tb: drives add, borrow, return and size requests
// under several retire limits with random stalls; depends on lwip_pkg and lwip_pool_model_pkg
`timescale 1ns / 100ps

module least_worn_item_pool_unit_tb;
  import lwip_pkg::*;
  import lwip_pool_model_pkg::*;

  localparam int PHASE_ITEMS = 160;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_func;
  logic [ID_BITS-1:0]   in_item_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_result_kind;
  logic [ID_BITS-1:0]   out_result_id;
  logic [SIZE_BITS-1:0] out_pool_count;
  logic [1:0]           out_error_code;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [1:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  item_pool_model pool_sb;
  bit             long_hold_req;

  least_worn_item_pool_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_item_id      (in_item_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_result_id   (out_result_id),
    .out_pool_count  (out_pool_count),
    .out_error_code  (out_error_code),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #6ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, calm stretches, and one long hold on request
  initial begin
    int hold;
    int calm;
    bit long_hold_taken;
    hold = 0;
    calm = 0;
    long_hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold = LONG_HOLD;
      end else if (hold == 0 && calm == 0) begin
        if ($urandom_range(0, 3) == 0) hold = pause_len();
        else if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 120);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (calm > 0) calm--;
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        pool_sb.check_result(out_result_kind, out_result_id, out_pool_count, out_error_code);
    end
  end

  // offer one request and wait until it is taken; valid stays high afterwards
  task automatic push_request(input logic [1:0] func, input logic [ID_BITS-1:0] id);
    in_valid   <= 1'b1;
    in_func    <= func;
    in_item_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool_sb.take_request(func, id);
  endtask

  task automatic pause_requests(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // mostly well-formed traffic, some misuse
  task automatic random_request();
    int               r;
    int               pick;
    logic [1:0]       func;
    logic [ID_BITS-1:0] id;
    r  = $urandom_range(0, 99);
    id = ID_BITS'($urandom_range(0, MAX_ITEMS - 1));
    if (r < 30) begin
      func = FUNC_ADD;
      if ($urandom_range(0, 9) < 8) begin
        pick = pool_sb.find_item(LOC_ABSENT);
        if (pick >= 0) id = ID_BITS'(pick);
      end
    end else if (r < 55) begin
      func = FUNC_BORROW;
    end else if (r < 88) begin
      func = FUNC_RETURN;
      if ($urandom_range(0, 9) < 8) begin
        pick = pool_sb.find_item(LOC_BORROWED);
        if (pick >= 0) id = ID_BITS'(pick);
      end
    end else begin
      func = FUNC_QUERY;
    end
    push_request(func, id);
  endtask

  // wait for every expected result, then let trailing no-result requests finish
  task automatic drain();
    in_valid <= 1'b0;
    while (pool_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write: setup phase, then access phase
  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    logic [31:0] data;
    data = {24'($urandom_range(0, 32'h00FF_FFFF)), 8'h00};
    data[LIMIT_BITS-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RETIRE_LIMIT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_sb.set_limit(value);
  endtask

  // main sequence
  initial begin
    logic [LIMIT_BITS-1:0] limits [8];
    bit                    gaps_on;
    pool_sb       = new();
    long_hold_req = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_func    <= FUNC_ADD;
    in_item_id <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= REG_RETIRE_LIMIT;
    pwdata     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pool, misuse, ordering by count then age
    push_request(FUNC_QUERY, 6'd0);
    push_request(FUNC_BORROW, 6'd0);
    push_request(FUNC_RETURN, 6'd7);
    push_request(FUNC_ADD, 6'd0);
    push_request(FUNC_ADD, 6'd63);
    push_request(FUNC_ADD, 6'd0);
    push_request(FUNC_ADD, 6'd42);
    push_request(FUNC_ADD, 6'd21);
    push_request(FUNC_QUERY, 6'd63);
    push_request(FUNC_BORROW, 6'd63);
    push_request(FUNC_ADD, 6'd0);
    push_request(FUNC_RETURN, 6'd0);
    push_request(FUNC_BORROW, 6'd0);
    push_request(FUNC_RETURN, 6'd63);
    push_request(FUNC_BORROW, 6'd0);
    push_request(FUNC_BORROW, 6'd0);
    push_request(FUNC_RETURN, 6'd42);
    push_request(FUNC_BORROW, 6'd0);
    push_request(FUNC_RETURN, 6'd0);
    push_request(FUNC_RETURN, 6'd0);
    push_request(FUNC_BORROW, 6'd0);
    push_request(FUNC_RETURN, 6'd0);
    push_request(FUNC_ADD, 6'd0);
    push_request(FUNC_QUERY, 6'd0);

    // limit per phase; phase 0 runs at the reset value
    limits[0] = LIMIT_RESET;
    limits[1] = 8'd1;
    limits[2] = 8'd255;
    limits[3] = 8'd0;
    limits[4] = 8'd2;
    limits[5] = 8'd5;
    limits[6] = LIMIT_BITS'($urandom_range(1, 255));
    limits[7] = LIMIT_BITS'($urandom_range(1, 255));

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        write_limit(limits[p]);
        @(posedge clk);
      end
      // back-to-back phases; one of them under a long result hold
      gaps_on = !(p == 2 || p == 5);
      if (p == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        if (gaps_on) pause_requests(pause_len());
      end
    end

    drain();
    if (pool_sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
